>>> rtl/rotating_lagged_fibonacci_rng_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the rotating lagged-Fibonacci generator
// Shared helpers; every macro samples on aclk and is off during reset.
// ---------------------------------------------------------------------------
`ifndef ROTATING_LAGGED_FIBONACCI_RNG_DEFINES_SVH
`define ROTATING_LAGGED_FIBONACCI_RNG_DEFINES_SVH

// same-cycle implication
`define RLFRNG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RLFRNG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rlfrng_pkg.sv
// ---------------------------------------------------------------------------
// rlfrng_pkg
// Constants, codes and types shared by the generator and its divider.
// ---------------------------------------------------------------------------
package rlfrng_pkg;

    localparam int WORD_W        = 32;
    localparam int RING_LENGTH   = 17;
    localparam int PARTNER_START = 10;
    localparam int POS_W         = $clog2(RING_LENGTH);
    localparam int DIV_CNT_W     = $clog2(WORD_W);

    localparam logic [WORD_W-1:0] LCG_MULT = 32'd2891336453;
    localparam int ROT_L = 13;
    localparam int ROT_R = 9;

    localparam logic [1:0] MODE_RESEED  = 2'd0;
    localparam logic [1:0] MODE_RAW     = 2'd1;
    localparam logic [1:0] MODE_BOUNDED = 2'd2;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

    // position walks downward and wraps to the top of the ring
    function automatic logic [POS_W-1:0] step_down(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] res;
        if (pos == '0) begin
            res = POS_W'(RING_LENGTH - 1);
        end else begin
            res = pos - POS_W'(1);
        end
        return res;
    endfunction

endpackage

>>> rtl/rlfrng_divider.sv
// ---------------------------------------------------------------------------
// rlfrng_divider
// Restoring radix-2 remainder unit, one bit per cycle over all WORD_W dividend bits.
// ---------------------------------------------------------------------------
`include "rotating_lagged_fibonacci_rng_defines.svh"

module rlfrng_divider
    import rlfrng_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  div_req_t          req,
    output logic              done,
    output logic [WORD_W-1:0] remainder
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0]    rem_reg, rem_next;
    logic [WORD_W-1:0]    dvd_reg, dvd_next;
    logic [WORD_W-1:0]    dsr_reg, dsr_next;
    logic [WORD_W:0]      trial;

    assign trial = {rem_reg, dvd_reg[WORD_W-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = WORD_W'(trial - {1'b0, dsr_reg});
            end else begin
                rem_next = trial[WORD_W-1:0];
            end
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(WORD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

    `RLFRNG_ASSERT_IMP(a_div_nonzero, req.start, req.divisor != '0, "zero divisor issued")
    `RLFRNG_ASSERT_IMP(a_div_rem_lt, done_reg, rem_reg < dsr_reg, "remainder not below divisor")
    `RLFRNG_ASSERT_IMP(a_div_excl, busy_reg, !done_reg, "busy and done together")

endmodule

>>> rtl/rotating_lagged_fibonacci_rng.sv
// ---------------------------------------------------------------------------
// rotating_lagged_fibonacci_rng
// RANROT-style generator on a 17-word ring held in a synchronous RAM.
// ---------------------------------------------------------------------------
// One input word carries a mode: reseed (0), raw word (1), word modulo bound
// (2); mode 3 is ignored and answered with zero. Every input word yields
// exactly one result word. Reseed fills the ring with 17 LCG steps
// (s = s*2891336453 + 1) and answers value 0. Generate reads ring[partner]
// and ring[write], stores rol(partner,13) + ror(write,9) at the write slot,
// returns it and moves both positions down with wrap. Bounded does the same
// and returns the word modulo bound through a bit-serial remainder unit; a
// zero bound sets bound_error, returns 0 and leaves the ring untouched.
// Words are taken one at a time. Raw runs read, calc and reply; bounded adds
// the bit-serial remainder loop between calc and reply; reseed runs the fill
// (one ring write per cycle, one LCG multiply per cycle) before reply; a zero
// bound or an unused mode goes straight to reply. The result word lands in
// the output register in the same cycle that s_ready returns. A result that
// finds the output register still full waits in the reply state until
// m_ready frees it. After reset the block fills the ring from
// seed 1 with s_ready low. The input side is taken again while a result
// still waits in the output register.
// ---------------------------------------------------------------------------
`include "rotating_lagged_fibonacci_rng_defines.svh"

module rotating_lagged_fibonacci_rng
    import rlfrng_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_mode,
    input  logic [WORD_W-1:0] s_seed_value,
    input  logic [WORD_W-1:0] s_bound,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [WORD_W-1:0] m_value,
    output logic              m_bound_error
);

    typedef enum logic [5:0] {
        ST_FILL  = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_CALC  = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_REPLY = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [POS_W-1:0]  wpos_reg, wpos_next;       // write position
    logic [POS_W-1:0]  ppos_reg, ppos_next;       // partner position
    logic [POS_W-1:0]  fcnt_reg, fcnt_next;       // fill index
    logic              fill_reply_reg, fill_reply_next;
    logic [WORD_W-1:0] lcg_reg, lcg_next;
    logic [1:0]        mode_reg, mode_next;
    logic [WORD_W-1:0] bound_reg, bound_next;
    logic [WORD_W-1:0] res_value_reg, res_value_next;
    logic              res_err_reg, res_err_next;
    logic              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0] m_value_reg, m_value_next;
    logic              m_err_reg, m_err_next;

    // ring RAM: one write port, two registered read ports
    logic [WORD_W-1:0] ring_mem [0:RING_LENGTH-1];
    logic [WORD_W-1:0] rd_w_reg, rd_p_reg;
    logic              ring_we;
    logic [POS_W-1:0]  ring_waddr;
    logic [WORD_W-1:0] ring_wdata;

    logic [WORD_W-1:0] lcg_step;
    logic [WORD_W-1:0] mix_word;
    logic              s_fire;
    logic              out_free;
    div_req_t          div_req;
    logic              div_done;
    logic [WORD_W-1:0] div_rem;

    // assertion helpers
    logic              pos_in_ring;
    logic              pos_lag_ok;
    logic [POS_W-1:0]  wpos_dn;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // low word of the LCG product only
    assign lcg_step = WORD_W'(lcg_reg * LCG_MULT) + WORD_W'(1);
    assign mix_word = {rd_p_reg[WORD_W-1-ROT_L:0], rd_p_reg[WORD_W-1:WORD_W-ROT_L]}
                    + {rd_w_reg[ROT_R-1:0], rd_w_reg[WORD_W-1:ROT_R]};

    always_comb begin
        state_next      = state_reg;
        wpos_next       = wpos_reg;
        ppos_next       = ppos_reg;
        fcnt_next       = fcnt_reg;
        fill_reply_next = fill_reply_reg;
        lcg_next        = lcg_reg;
        mode_next       = mode_reg;
        bound_next      = bound_reg;
        res_value_next  = res_value_reg;
        res_err_next    = res_err_reg;
        m_valid_next    = m_valid_reg;
        m_value_next    = m_value_reg;
        m_err_next      = m_err_reg;
        ring_we         = 1'b0;
        ring_waddr      = wpos_reg;
        ring_wdata      = mix_word;
        div_req.start    = 1'b0;
        div_req.dividend = mix_word;
        div_req.divisor  = bound_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_FILL: begin
                ring_we    = 1'b1;
                ring_waddr = fcnt_reg;
                ring_wdata = lcg_step;
                lcg_next   = lcg_step;
                fcnt_next  = fcnt_reg + POS_W'(1);
                if (fcnt_reg == POS_W'(RING_LENGTH - 1)) begin
                    wpos_next      = '0;
                    ppos_next      = POS_W'(PARTNER_START % RING_LENGTH);
                    res_value_next = '0;
                    res_err_next   = 1'b0;
                    state_next     = fill_reply_reg ? ST_REPLY : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    mode_next      = s_mode;
                    bound_next     = s_bound;
                    res_value_next = '0;
                    res_err_next   = 1'b0;
                    case (s_mode)
                        MODE_RESEED: begin
                            lcg_next        = s_seed_value;
                            fcnt_next       = '0;
                            fill_reply_next = 1'b1;
                            state_next      = ST_FILL;
                        end
                        MODE_RAW: begin
                            state_next = ST_READ;
                        end
                        MODE_BOUNDED: begin
                            if (s_bound == '0) begin
                                res_err_next = 1'b1;
                                state_next   = ST_REPLY;
                            end else begin
                                state_next = ST_READ;
                            end
                        end
                        default: begin
                            state_next = ST_REPLY;
                        end
                    endcase
                end
            end
            ST_READ: begin
                // read ports capture both ring slots at this edge
                state_next = ST_CALC;
            end
            ST_CALC: begin
                ring_we   = 1'b1;
                wpos_next = step_down(wpos_reg);
                ppos_next = step_down(ppos_reg);
                if (mode_reg == MODE_BOUNDED) begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    res_value_next = mix_word;
                    state_next     = ST_REPLY;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    res_value_next = div_rem;
                    state_next     = ST_REPLY;
                end
            end
            ST_REPLY: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_value_next = res_value_reg;
                    m_err_next   = res_err_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_FILL;
            wpos_reg       <= '0;
            ppos_reg       <= POS_W'(PARTNER_START % RING_LENGTH);
            fcnt_reg       <= '0;
            fill_reply_reg <= 1'b0;
            lcg_reg        <= WORD_W'(1);
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            wpos_reg       <= wpos_next;
            ppos_reg       <= ppos_next;
            fcnt_reg       <= fcnt_next;
            fill_reply_reg <= fill_reply_next;
            lcg_reg        <= lcg_next;
            m_valid_reg    <= m_valid_next;
        end
        mode_reg      <= mode_next;
        bound_reg     <= bound_next;
        res_value_reg <= res_value_next;
        res_err_reg   <= res_err_next;
        m_value_reg   <= m_value_next;
        m_err_reg     <= m_err_next;
    end

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        rd_w_reg <= ring_mem[wpos_reg];
        rd_p_reg <= ring_mem[ppos_reg];
    end

    rlfrng_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (div_req),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign m_valid       = m_valid_reg;
    assign m_value       = m_value_reg;
    assign m_bound_error = m_err_reg;

    // partner sits PARTNER_START slots above the write slot, modulo the ring
    assign pos_in_ring = (wpos_reg < POS_W'(RING_LENGTH)) && (ppos_reg < POS_W'(RING_LENGTH));
    assign pos_lag_ok  = ({1'b0, ppos_reg} == {1'b0, wpos_reg} + (POS_W+1)'(PARTNER_START))
                      || ({1'b0, ppos_reg} + (POS_W+1)'(RING_LENGTH - PARTNER_START)
                          == {1'b0, wpos_reg});
    assign wpos_dn     = step_down(wpos_reg);

    `RLFRNG_ASSERT_IMP(a_pos_range, 1'b1, pos_in_ring, "position out of ring")
    `RLFRNG_ASSERT_IMP(a_pos_lag, state_reg != ST_FILL, pos_lag_ok, "partner lag lost")
    `RLFRNG_ASSERT_IMP(a_err_zero, m_valid_reg && m_err_reg, m_value_reg == '0, "error data")
    `RLFRNG_ASSERT_NXT(a_calc_step, state_reg == ST_CALC, wpos_reg == $past(wpos_dn), "no step")

endmodule
